// ===== design/button_link_retry_backoff_core_assert.svh =====
`ifndef BUTTON_LINK_RETRY_BACKOFF_CORE_ASSERT_SVH
`define BUTTON_LINK_RETRY_BACKOFF_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define BLRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define BLRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/blrb_pkg.sv =====
package blrb_pkg;

    localparam logic [1:0] CMD_BUTTON = 2'd0;
    localparam logic [1:0] CMD_IRQ    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] REG_TICK_STEP     = 3'd0;
    localparam logic [2:0] REG_KEEPALIVE     = 3'd1;
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd2;
    localparam logic [2:0] REG_FIRST_BACKOFF = 3'd3;
    localparam logic [2:0] REG_MAX_BACKOFF   = 3'd4;

    localparam logic [7:0]  TICK_STEP_RESET     = 8'd10;
    localparam logic [15:0] KEEPALIVE_RESET     = 16'd1000;
    localparam logic [7:0]  RETRY_LIMIT_RESET   = 8'd3;
    localparam logic [15:0] FIRST_BACKOFF_RESET = 16'd10;
    localparam logic [15:0] MAX_BACKOFF_RESET   = 16'd1000;

    localparam logic [7:0] FAIL_COUNT_MAX = 8'd255;

    localparam int IRQ_MAX_RT_BIT = 4;
    localparam int IRQ_TX_OK_BIT  = 5;

    localparam logic [1:0] MODE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_CODE_SENDING = 2'd1;
    localparam logic [1:0] MODE_CODE_WAIT    = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_SENDING = 3'b010,
        MODE_WAIT    = 3'b100
    } mode_t;

    typedef struct packed {
        logic [7:0]  tick_step_ms;
        logic [15:0] keepalive_ms;
        logic [7:0]  retry_limit;
        logic [15:0] first_backoff_ms;
        logic [15:0] max_backoff_ms;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] elapsed_ms;
        logic [15:0] backoff_ms;
        logic [7:0]  current_buttons;
        logic [7:0]  inflight_buttons;
        logic [7:0]  acked_buttons;
        logic        acked_valid;
        logic [7:0]  fail_count;
        logic        indicator;
    } link_state_t;

    typedef struct packed {
        logic       send;
        logic [7:0] payload;
        logic       flush_tx;
        logic       clear_irq;
        logic       indicator;
        logic [1:0] mode;
    } result_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] buttons;
        logic [7:0] irq_status;
    } item_t;

endpackage

// ===== design/blrb_cfg.sv =====
module blrb_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output blrb_pkg::cfg_t     cfg
);
    import blrb_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step_ms     <= TICK_STEP_RESET;
            cfg_reg.keepalive_ms     <= KEEPALIVE_RESET;
            cfg_reg.retry_limit      <= RETRY_LIMIT_RESET;
            cfg_reg.first_backoff_ms <= FIRST_BACKOFF_RESET;
            cfg_reg.max_backoff_ms   <= MAX_BACKOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TICK_STEP:     cfg_reg.tick_step_ms     <= cfg_data[7:0];
                REG_KEEPALIVE:     cfg_reg.keepalive_ms     <= cfg_data;
                REG_RETRY_LIMIT:   cfg_reg.retry_limit      <= cfg_data[7:0];
                REG_FIRST_BACKOFF: cfg_reg.first_backoff_ms <= cfg_data;
                REG_MAX_BACKOFF:   cfg_reg.max_backoff_ms   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/blrb_step.sv =====
module blrb_step (
    input  blrb_pkg::item_t       item,
    input  blrb_pkg::cfg_t        cfg,
    input  blrb_pkg::link_state_t state,
    output blrb_pkg::link_state_t state_next,
    output blrb_pkg::result_t     result
);
    import blrb_pkg::*;

    logic [7:0]  fail_inc;
    logic [16:0] backoff_dbl;
    logic [15:0] backoff_capped;
    logic [15:0] elapsed_inc;

    assign fail_inc = (state.fail_count == FAIL_COUNT_MAX) ? FAIL_COUNT_MAX
                                                          : state.fail_count + 8'd1;
    assign backoff_dbl = {state.backoff_ms, 1'b0};
    assign backoff_capped = (backoff_dbl > {1'b0, cfg.max_backoff_ms}) ? cfg.max_backoff_ms
                                                                       : backoff_dbl[15:0];
    assign elapsed_inc = state.elapsed_ms + {8'd0, cfg.tick_step_ms};

    always_comb
    begin
        logic do_send;
        logic fresh;
        logic [7:0] send_byte;

        state_next = state;
        do_send = 1'b0;
        fresh = 1'b0;
        send_byte = state.current_buttons;
        result.flush_tx = 1'b0;
        result.clear_irq = 1'b0;

        unique case (item.command)
            CMD_BUTTON:
            begin
                state_next.current_buttons = item.buttons;
                send_byte = item.buttons;
                if ((state.mode == MODE_IDLE || state.mode == MODE_WAIT) &&
                    (!state.acked_valid || item.buttons != state.acked_buttons))
                begin
                    do_send = 1'b1;
                    fresh = 1'b1;
                end
            end
            CMD_IRQ:
            begin
                state_next.indicator = 1'b0;
                result.clear_irq = 1'b1;
                if (item.irq_status[IRQ_MAX_RT_BIT])
                begin
                    result.flush_tx = 1'b1;
                    state_next.acked_valid = 1'b0;
                    state_next.fail_count = fail_inc;
                    if (fail_inc < cfg.retry_limit)
                    begin
                        do_send = 1'b1;
                    end
                    else
                    begin
                        state_next.backoff_ms = (fail_inc == cfg.retry_limit)
                                                ? cfg.first_backoff_ms : backoff_capped;
                        state_next.mode = MODE_WAIT;
                        state_next.elapsed_ms = 16'd0;
                    end
                end
                else if (item.irq_status[IRQ_TX_OK_BIT])
                begin
                    state_next.acked_buttons = state.inflight_buttons;
                    state_next.acked_valid = 1'b1;
                    if (state.current_buttons != state.inflight_buttons)
                    begin
                        do_send = 1'b1;
                        fresh = 1'b1;
                    end
                    else
                    begin
                        state_next.mode = MODE_IDLE;
                        state_next.elapsed_ms = 16'd0;
                    end
                end
            end
            CMD_TICK:
            begin
                state_next.elapsed_ms = elapsed_inc;
                if (state.mode == MODE_IDLE && elapsed_inc > cfg.keepalive_ms)
                begin
                    do_send = 1'b1;
                    fresh = 1'b1;
                end
                else if (state.mode == MODE_WAIT && elapsed_inc >= state.backoff_ms)
                begin
                    do_send = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_send)
        begin
            state_next.mode = MODE_SENDING;
            state_next.elapsed_ms = 16'd0;
            state_next.indicator = 1'b1;
            state_next.inflight_buttons = send_byte;
            if (fresh)
            begin
                state_next.fail_count = 8'd0;
            end
        end

        result.send = do_send;
        result.payload = do_send ? send_byte : 8'd0;
        result.indicator = state_next.indicator;
        unique case (state_next.mode)
            MODE_IDLE:    result.mode = MODE_CODE_IDLE;
            MODE_SENDING: result.mode = MODE_CODE_SENDING;
            MODE_WAIT:    result.mode = MODE_CODE_WAIT;
            default:      result.mode = MODE_CODE_IDLE;
        endcase
    end

endmodule

// ===== design/button_link_retry_backoff_core.sv =====
// an accepted item is held in the input register; its result is then registered in the output register
// throughput: one item per cycle while results are taken, set by the combinational step logic
// while a result waits, the input register takes one more item, then in_ready drops
// until the result is taken
// reset: rst_n, asynchronous active low, clears the link state, both valid flags and
// returns the configuration registers to their defaults
`include "button_link_retry_backoff_core_assert.svh"

module button_link_retry_backoff_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  buttons,
    input  logic [7:0]  irq_status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send,
    output logic [7:0]  payload,
    output logic        flush_tx,
    output logic        clear_irq,
    output logic        indicator,
    output logic [1:0]  mode
);
    import blrb_pkg::*;

    cfg_t        cfg;
    item_t       item_reg;
    logic        item_valid_reg;
    link_state_t state_reg;
    link_state_t state_next;
    result_t     result_next;
    result_t     result_reg;
    logic        result_valid_reg;
    logic        advance;

    blrb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blrb_step u_step (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance  = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command    <= command;
            item_reg.buttons    <= buttons;
            item_reg.irq_status <= irq_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= MODE_IDLE;
            state_reg.elapsed_ms       <= 16'd0;
            state_reg.backoff_ms       <= 16'd0;
            state_reg.current_buttons  <= 8'd0;
            state_reg.inflight_buttons <= 8'd0;
            state_reg.acked_buttons    <= 8'd0;
            state_reg.acked_valid      <= 1'b0;
            state_reg.fail_count       <= 8'd0;
            state_reg.indicator        <= 1'b0;
            result_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                result_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = result_valid_reg;
    assign send      = result_reg.send;
    assign payload   = result_reg.payload;
    assign flush_tx  = result_reg.flush_tx;
    assign clear_irq = result_reg.clear_irq;
    assign indicator = result_reg.indicator;
    assign mode      = result_reg.mode;

    `BLRB_ASSERT_NOW(a_send_sets_mode, clk, rst_n, out_valid && send,
                     indicator && mode == MODE_CODE_SENDING)
    `BLRB_ASSERT_NOW(a_flush_on_irq, clk, rst_n, out_valid && flush_tx,
                     clear_irq && indicator == send)
    `BLRB_ASSERT_NOW(a_payload_idle_zero, clk, rst_n, out_valid && !send, payload == 8'd0)
    `BLRB_ASSERT_NEXT(a_stalled_item_held, clk, rst_n, item_valid_reg && !advance,
                      item_valid_reg && $stable(item_reg))
    `BLRB_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, result_valid_reg)

endmodule

// ===== tb/button_link_retry_backoff_core_test.sv =====
module button_link_retry_backoff_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import blrb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0] ST_MAX_RT  = 8'h01 << IRQ_MAX_RT_BIT;
    localparam logic [7:0] ST_TX_OK   = 8'h01 << IRQ_TX_OK_BIT;
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         MAX_REPORTS = 10;
    localparam int         BURST_LIMIT_CAP = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [7:0]  buttons = '0;
    logic [7:0]  irq_status = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        send;
    logic [7:0]  payload;
    logic        flush_tx;
    logic        clear_irq;
    logic        indicator;
    logic [1:0]  mode;

    button_link_retry_backoff_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .buttons    (buttons),
        .irq_status (irq_status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .send       (send),
        .payload    (payload),
        .flush_tx   (flush_tx),
        .clear_irq  (clear_irq),
        .indicator  (indicator),
        .mode       (mode)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // configuration copy
    logic [7:0]  c_tick  = TICK_STEP_RESET;
    logic [15:0] c_keep  = KEEPALIVE_RESET;
    logic [7:0]  c_limit = RETRY_LIMIT_RESET;
    logic [15:0] c_first = FIRST_BACKOFF_RESET;
    logic [15:0] c_max   = MAX_BACKOFF_RESET;

    // link state copy
    logic [1:0]  lk_mode  = MODE_CODE_IDLE;
    logic [15:0] elapsed  = '0;
    logic [15:0] backoff  = '0;
    logic [7:0]  cur_btn  = '0;
    logic [7:0]  infl_btn = '0;
    logic [7:0]  ack_btn  = '0;
    logic        ack_ok   = 1'b0;
    logic [7:0]  fails    = '0;
    logic        ind      = 1'b0;
    logic        tx_flag;
    logic [7:0]  tx_byte;

    item_t       pending_items[$];
    result_t     expected_results[$];
    int unsigned issued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned queued_total = 0;
    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 36;
    int unsigned hold_trigger = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic [7:0]  last_btn = '0;

    function automatic void link_retry();
        lk_mode  = MODE_CODE_SENDING;
        elapsed  = '0;
        ind      = 1'b1;
        infl_btn = cur_btn;
        tx_flag  = 1'b1;
        tx_byte  = cur_btn;
    endfunction

    function automatic void link_fresh_send();
        fails = '0;
        link_retry();
    endfunction

    function automatic result_t predict_link_step(item_t it);
        result_t     r;
        logic [16:0] dbl;
        r = '0;
        tx_flag = 1'b0;
        tx_byte = '0;
        case (it.command)
            CMD_BUTTON:
            begin
                cur_btn = it.buttons;
                if ((lk_mode == MODE_CODE_IDLE || lk_mode == MODE_CODE_WAIT) &&
                    (!ack_ok || cur_btn != ack_btn))
                    link_fresh_send();
            end
            CMD_IRQ:
            begin
                ind = 1'b0;
                r.clear_irq = 1'b1;
                if (it.irq_status[IRQ_MAX_RT_BIT])
                begin
                    r.flush_tx = 1'b1;
                    ack_ok = 1'b0;
                    if (fails != FAIL_COUNT_MAX)
                        fails = fails + 8'd1;
                    if (fails < c_limit)
                        link_retry();
                    else
                    begin
                        if (fails == c_limit)
                            backoff = c_first;
                        else
                        begin
                            dbl = {backoff, 1'b0};
                            if (dbl > {1'b0, c_max})
                                dbl = {1'b0, c_max};
                            backoff = dbl[15:0];
                        end
                        lk_mode = MODE_CODE_WAIT;
                        elapsed = '0;
                    end
                end
                else if (it.irq_status[IRQ_TX_OK_BIT])
                begin
                    ack_btn = infl_btn;
                    ack_ok = 1'b1;
                    if (cur_btn != ack_btn)
                        link_fresh_send();
                    else
                    begin
                        lk_mode = MODE_CODE_IDLE;
                        elapsed = '0;
                    end
                end
            end
            CMD_TICK:
            begin
                elapsed = elapsed + {8'h00, c_tick};
                if (lk_mode == MODE_CODE_IDLE && elapsed > c_keep)
                    link_fresh_send();
                else if (lk_mode == MODE_CODE_WAIT && elapsed >= backoff)
                    link_retry();
            end
            default:
            begin
            end
        endcase
        r.send      = tx_flag;
        r.payload   = tx_byte;
        r.indicator = ind;
        r.mode      = lk_mode;
        return r;
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n && issued_count == accepted_count)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                command    <= pending_items[0].command;
                buttons    <= pending_items[0].buttons;
                irq_status <= pending_items[0].irq_status;
                in_valid   <= 1'b1;
                void'(pending_items.pop_front());
                issued_count = issued_count + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check and input capture
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_t   it;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{send, payload, flush_tx, clear_irq, indicator, mode};
                if (expected_results.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("unexpected result: send %0d payload %h ",
                               got.send, got.payload);
                        $display("flush %0d clr %0d ind %0d mode %0d",
                                 got.flush_tx, got.clear_irq, got.indicator, got.mode);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.send !== want.send || got.payload !== want.payload ||
                        got.flush_tx !== want.flush_tx || got.clear_irq !== want.clear_irq ||
                        got.indicator !== want.indicator || got.mode !== want.mode)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $write("mismatch: send %0d/%0d payload %h/%h flush %0d/%0d ",
                                   want.send, got.send, want.payload, got.payload,
                                   want.flush_tx, got.flush_tx);
                            $display("clr %0d/%0d ind %0d/%0d mode %0d/%0d (exp/act)",
                                     want.clear_irq, got.clear_irq,
                                     want.indicator, got.indicator, want.mode, got.mode);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                it = '{command, buttons, irq_status};
                expected_results.push_back(predict_link_step(it));
                accepted_count = accepted_count + 1;
            end
        end
    end

    task automatic push_item(logic [1:0] cmd, logic [7:0] btn, logic [7:0] st);
        item_t it;
        it = '{cmd, btn, st};
        pending_items.push_back(it);
        queued_total = queued_total + 1;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || issued_count != accepted_count ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TICK_STEP:     c_tick  = data[7:0];
            REG_KEEPALIVE:     c_keep  = data;
            REG_RETRY_LIMIT:   c_limit = data[7:0];
            REG_FIRST_BACKOFF: c_first = data;
            REG_MAX_BACKOFF:   c_max   = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_config(logic [7:0] tick, logic [15:0] keep, logic [7:0] limit,
                                logic [15:0] first, logic [15:0] maxb);
        write_reg(REG_TICK_STEP, {8'h00, tick});
        write_reg(REG_KEEPALIVE, keep);
        write_reg(REG_RETRY_LIMIT, {8'h00, limit});
        write_reg(REG_FIRST_BACKOFF, first);
        write_reg(REG_MAX_BACKOFF, maxb);
    endtask

    task automatic gen_phase(int unsigned n);
        int unsigned start;
        int unsigned kind;
        int unsigned k;
        int unsigned burst_base;
        logic [7:0]  btn;
        start = queued_total;
        while (queued_total - start < n)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                btn = ($urandom_range(3) == 0) ? last_btn : rand_byte();
                last_btn = btn;
                push_item(CMD_BUTTON, btn, rand_byte());
                if ($urandom_range(4) != 0)
                    push_item(CMD_IRQ, rand_byte(), (rand_byte() & ~ST_MAX_RT) | ST_TX_OK);
                else
                    push_item(CMD_IRQ, rand_byte(), rand_byte() | ST_MAX_RT);
            end
            else if (kind < 55)
            begin
                burst_base = (int'(c_limit) > BURST_LIMIT_CAP) ? BURST_LIMIT_CAP
                                                                : int'(c_limit);
                k = $urandom_range(burst_base + 6, 1);
                repeat (k)
                begin
                    push_item(CMD_IRQ, rand_byte(), rand_byte() | ST_MAX_RT);
                    repeat ($urandom_range(3)) push_item(CMD_TICK, rand_byte(), rand_byte());
                end
                push_item(CMD_IRQ, rand_byte(), (rand_byte() & ~ST_MAX_RT) | ST_TX_OK);
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(40, 1)) push_item(CMD_TICK, rand_byte(), rand_byte());
            end
            else
                push_item(2'($urandom_range(3)), rand_byte(), rand_byte());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        push_item(CMD_UNUSED, 8'hFF, 8'hFF);
        push_item(CMD_BUTTON, 8'h00, 8'h00);
        push_item(CMD_IRQ, 8'h00, ST_TX_OK);
        push_item(CMD_BUTTON, 8'h00, 8'h00);
        push_item(CMD_BUTTON, 8'hFF, 8'h00);
        push_item(CMD_BUTTON, 8'hAA, 8'h00);
        push_item(CMD_IRQ, 8'h00, ST_MAX_RT | ST_TX_OK);
        push_item(CMD_IRQ, 8'h00, ST_MAX_RT);
        push_item(CMD_IRQ, 8'h00, ST_MAX_RT);
        push_item(CMD_TICK, 8'h00, 8'h00);
        push_item(CMD_IRQ, 8'h00, ST_MAX_RT);
        push_item(CMD_TICK, 8'h00, 8'h00);
        push_item(CMD_TICK, 8'h00, 8'h00);
        push_item(CMD_IRQ, 8'h00, ~(ST_MAX_RT | ST_TX_OK));
        push_item(CMD_IRQ, 8'h00, ST_TX_OK);
        push_item(CMD_IRQ, 8'h00, 8'hFF);
        push_item(CMD_BUTTON, 8'h00, 8'h00);
        push_item(CMD_IRQ, 8'hFF, ST_TX_OK);
        push_item(CMD_UNUSED, 8'h00, 8'h00);
        push_item(CMD_BUTTON, 8'h55, 8'hFF);
        wait_drained();

        // reset configuration, receiver held off while the sender keeps offering
        gen_phase(300);
        hold_trigger = hold_trigger + 1;
        wait_drained();

        // low extremes, indexes past the last register are ignored
        apply_config(8'd1, 16'd0, 8'd1, 16'd0, 16'd0);
        for (int k = REG_MAX_BACKOFF + 1; k < 8; k++)
            write_reg(3'(k), 16'($urandom_range(65535)));
        gen_phase(250);
        wait_drained();

        // high extremes with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(8'd255, 16'd65535, 8'd254, 16'd65535, 16'd65535);
        gen_phase(300);
        wait_drained();
        send_idle_pct = 36;
        recv_idle_pct = 36;

        apply_config(8'd50, 16'd300, 8'd4, 16'd40, 16'd65535);
        gen_phase(300);
        wait_drained();

        apply_config(8'd255, 16'd65535, 8'd2, 16'd0, 16'd500);
        gen_phase(200);
        wait_drained();

        apply_config(8'($urandom_range(255, 1)), 16'($urandom_range(2000)),
                     8'($urandom_range(8, 1)), 16'($urandom_range(300)),
                     16'($urandom_range(65535)));
        gen_phase(300);
        hold_trigger = hold_trigger + 1;
        wait_drained();

        apply_config(8'($urandom_range(255, 1)), 16'($urandom_range(65535)),
                     8'($urandom_range(254, 1)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
        gen_phase(200);
        wait_drained();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
